// File: rtl/fpfa_pkg.sv
// Shared types and constants of the fixed-partition fit allocator.
package fpfa_pkg;

  localparam int MAX_PARTITIONS = 16;
  localparam int SIZE_BITS      = 16;

  localparam int IDX_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);

  localparam int CMD_W     = 2;
  localparam int SLOT_W    = 4;
  localparam int AMOUNT_W  = 16;
  localparam int STATUS_W  = 3;
  localparam int POLICY_W  = 2;
  localparam int BLOCKS_W  = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DW    = BLOCKS_W;

  localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 1'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_ALLOC   = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_GRANTED  = 3'd0,
    STS_NOFIT    = 3'd1,
    STS_LOADED   = 3'd2,
    STS_RELEASED = 3'd3,
    STS_BADSLOT  = 3'd4
  } status_e;

  typedef enum logic [POLICY_W-1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2
  } policy_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_e;

  // Context of the candidate under test for the fit compare unit.
  typedef struct packed {
    policy_e policy;
    logic    found;
    logic    busy;
  } fit_ctx_t;

endpackage

// File: rtl/fpfa_fit_unit.sv
// Shared compare unit: decides whether one scanned partition becomes the pick.
module fpfa_fit_unit (
  input  fpfa_pkg::fit_ctx_t                ctx_i,
  input  logic [fpfa_pkg::SIZE_BITS-1:0]    want_i,
  input  logic [fpfa_pkg::SIZE_BITS-1:0]    cand_size_i,
  input  logic [fpfa_pkg::SIZE_BITS-1:0]    best_size_i,
  output logic                              take_o
);
  import fpfa_pkg::*;

  logic fits;

  assign fits = !ctx_i.busy && (cand_size_i >= want_i);

  always_comb begin
    case (ctx_i.policy)
      POL_FIRST: take_o = fits && !ctx_i.found;
      POL_BEST:  take_o = fits && (!ctx_i.found || (cand_size_i < best_size_i));
      POL_WORST: take_o = fits && (!ctx_i.found || (cand_size_i > best_size_i));
      default:   take_o = 1'b0;
    endcase
  end

endmodule

// File: rtl/fixed_partition_fit_allocator.sv
// Top level of the fixed-partition fit allocator: table, scan sequencer, result register.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------------
//  in      | sink      | in_valid_i / in_stall_o | command_i, slot_i, amount_i
//  out     | source    | out_valid_o / out_stall_i | status_o, granted_slot_o, granted_size_o
//  cfg     | sink      | cfg_we_i                | cfg_index_i, cfg_data_i
//
// Load and release update the table at accept; the result then waits in ST_RESULT
// and is handed to the output register once that register is empty or draining.
// Allocate scans the first min(blocks_in_use, MAX_PARTITIONS) partitions: the size
// memory has one registered read port, so the scan reads one partition a cycle and
// feeds the single compare unit, then drains the last compare and hands off.
// Reset clears the busy bits, the configuration registers, the output valid flag and
// the sequencer; the size memory holds garbage until loaded. A stalled result waits
// in the output register while the next beat is taken and worked on.
module fixed_partition_fit_allocator (
  input  logic                               clk_i,
  input  logic                               rst_ni,

  input  logic                               cfg_we_i,
  input  logic [fpfa_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [fpfa_pkg::CFG_DW-1:0]        cfg_data_i,

  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [fpfa_pkg::CMD_W-1:0]         command_i,
  input  logic [fpfa_pkg::SLOT_W-1:0]        slot_i,
  input  logic [fpfa_pkg::AMOUNT_W-1:0]      amount_i,

  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [fpfa_pkg::STATUS_W-1:0]      status_o,
  output logic [fpfa_pkg::SLOT_W-1:0]        granted_slot_o,
  output logic [fpfa_pkg::AMOUNT_W-1:0]      granted_size_o
);
  import fpfa_pkg::*;

  // Configuration registers
  logic [POLICY_W-1:0] fit_policy_q;
  logic [BLOCKS_W-1:0] blocks_q;
  logic [CNT_W-1:0]    limit;

  // Partition table
  logic [SIZE_BITS-1:0]      mem [MAX_PARTITIONS];
  logic [SIZE_BITS-1:0]      rd_data_q;
  logic                      mem_we;
  logic [IDX_W-1:0]          mem_waddr;
  logic [MAX_PARTITIONS-1:0] busy_q, busy_d;

  // Sequencer and scan state
  state_e               state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 pend_q, pend_d;
  logic [IDX_W-1:0]     pend_idx_q, pend_idx_d;
  logic                 found_q, found_d;
  logic [IDX_W-1:0]     pick_q, pick_d;
  logic [SIZE_BITS-1:0] best_q, best_d;
  logic [SIZE_BITS-1:0] want_q, want_d;

  // Pending result and output register
  status_e              res_status_q, res_status_d;
  logic [IDX_W-1:0]     res_slot_q, res_slot_d;
  logic [SIZE_BITS-1:0] res_size_q, res_size_d;
  logic                 out_valid_q;
  status_e              out_status_q;
  logic [SLOT_W-1:0]    out_slot_q;
  logic [AMOUNT_W-1:0]  out_size_q;

  logic     in_accept;
  logic     xfer;
  logic     take;
  fit_ctx_t ctx;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  // Hand the pending result over when the output register is empty or draining.
  assign xfer       = (state_q == ST_RESULT) && (!out_valid_q || !out_stall_i);

  // Clamp the partition count to the table depth.
  assign limit = (32'(blocks_q) > 32'(MAX_PARTITIONS)) ? CNT_W'(MAX_PARTITIONS)
                                                       : CNT_W'(blocks_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_policy_q <= '0;
      blocks_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FIT_POLICY:    fit_policy_q <= cfg_data_i[POLICY_W-1:0];
        CFG_BLOCKS_IN_USE: blocks_q     <= cfg_data_i[BLOCKS_W-1:0];
        default: ;
      endcase
    end
  end

  // Size memory: one write port at accept, one registered read port for the scan.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= SIZE_BITS'(amount_i);
    end
    rd_data_q <= mem[cnt_q[IDX_W-1:0]];
  end

  assign ctx.policy = policy_e'(fit_policy_q);
  assign ctx.found  = found_q;
  assign ctx.busy   = busy_q[pend_idx_q];

  fpfa_fit_unit u_fit (
    .ctx_i       (ctx),
    .want_i      (want_q),
    .cand_size_i (rd_data_q),
    .best_size_i (best_q),
    .take_o      (take)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= '0;
      pend_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
      pend_q  <= pend_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q        <= cnt_d;
    pend_idx_q   <= pend_idx_d;
    pick_q       <= pick_d;
    best_q       <= best_d;
    want_q       <= want_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_size_q   <= res_size_d;
  end

  always_comb begin
    state_d      = state_q;
    busy_d       = busy_q;
    cnt_d        = cnt_q;
    pend_d       = pend_q;
    pend_idx_d   = pend_idx_q;
    found_d      = found_q;
    pick_d       = pick_q;
    best_d       = best_q;
    want_d       = want_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_size_d   = res_size_q;
    mem_we       = 1'b0;
    mem_waddr    = IDX_W'(slot_i);

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          res_slot_d = '0;
          res_size_d = '0;
          case (command_i)
            CMD_LOAD: begin
              if (32'(slot_i) >= 32'(MAX_PARTITIONS)) begin
                res_status_d = STS_BADSLOT;
              end else begin
                mem_we                  = 1'b1;
                busy_d[IDX_W'(slot_i)]  = 1'b0;
                res_status_d            = STS_LOADED;
              end
              state_d = ST_RESULT;
            end
            CMD_ALLOC: begin
              want_d  = SIZE_BITS'(amount_i);
              cnt_d   = '0;
              pend_d  = 1'b0;
              found_d = 1'b0;
              state_d = ST_SCAN;
            end
            CMD_RELEASE: begin
              busy_d       = '0;
              res_status_d = STS_RELEASED;
              state_d      = ST_RESULT;
            end
            default: ; // drop unknown commands without a result
          endcase
        end
      end

      ST_SCAN: begin
        // Issue the next read while the previous one is compared.
        if (cnt_q < limit) begin
          pend_d     = 1'b1;
          pend_idx_d = cnt_q[IDX_W-1:0];
          cnt_d      = cnt_q + 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q && take) begin
          found_d = 1'b1;
          pick_d  = pend_idx_q;
          best_d  = rd_data_q;
        end
        if (!(cnt_q < limit) && !pend_q) begin
          if (found_q) begin
            busy_d[pick_q] = 1'b1;
            res_status_d   = STS_GRANTED;
            res_slot_d     = pick_q;
            res_size_d     = best_q;
          end else begin
            res_status_d = STS_NOFIT;
            res_slot_d   = '0;
            res_size_d   = '0;
          end
          state_d = ST_RESULT;
        end
      end

      ST_RESULT: begin
        if (xfer) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Output register: hold while stalled, load a fresh result on handoff.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (xfer) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (xfer) begin
      out_status_q <= res_status_q;
      out_slot_q   <= SLOT_W'(res_slot_q);
      out_size_q   <= AMOUNT_W'(res_size_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign granted_slot_o = out_slot_q;
  assign granted_size_o = out_size_q;

  // A granted partition is marked busy by the time its result reaches the output.
  a_grant_marks_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xfer && res_status_q == STS_GRANTED) |=> busy_q[IDX_W'(granted_slot_o)])
    else $error("granted partition not marked busy");

  // Results other than a grant carry zero index and size.
  a_nogrant_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != STS_GRANTED) |-> (granted_slot_o == '0 && granted_size_o == '0))
    else $error("non-grant result with nonzero payload");

  // The pick never lies outside the partitions in use.
  a_pick_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && found_q) |-> (CNT_W'(pick_q) < limit))
    else $error("scan pick beyond partitions in use");

endmodule
